>>> rtl/lca_pkg.sv
// lca_pkg: shared sizes, command codes and sequencer states for the lca engine
// no dependencies
package lca_pkg;

	localparam int MAX_NODES   = 512;
	localparam int JUMP_LEVELS = 9;

	localparam int NODE_W  = 9;
	localparam int DEPTH_W = 9;
	localparam int LINK_W  = NODE_W + 1;
	localparam int LVL_W   = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
	localparam int JT_DEPTH = JUMP_LEVELS * MAX_NODES;
	localparam int JT_AW   = $clog2(JT_DEPTH);
	localparam int CMP_W   = ((DEPTH_W > JUMP_LEVELS) ? DEPTH_W : JUMP_LEVELS) + 1;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_BUILD = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_B_RD,
		S_B_MID,
		S_B_WR,
		S_Q_SWAP,
		S_L_CHK,
		S_L_JMP,
		S_L_DEP,
		S_L_END,
		S_C_RD,
		S_C_CHK,
		S_P_RD,
		S_P_CHK
	} state_t;

endpackage

>>> rtl/lca_ram.sv
// lca_ram: generic memory, one write port and two registered read ports
// no dependencies
module lca_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> rtl/tree_lca_binary_lifting.sv
// tree_lca_binary_lifting: sequencer and compare unit of the lca engine over parent,
// depth and jump memories; depends on lca_pkg and lca_ram
// a write or unused command finishes straight from idle; a query lifts the deeper node
// level by level, then climbs both nodes together; a build fills the jump table level by
// level, node by node. one request at a time; busy is high while a build or query runs;
// done lasts one cycle and cannot be held off by the receiver.
// after reset a clearing pass zeroes parent and depth memories, busy high.
module tree_lca_binary_lifting (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                command,
	input  logic [lca_pkg::NODE_W-1:0]  node,
	input  logic [lca_pkg::NODE_W-1:0]  parent_node,
	input  logic                      has_parent,
	input  logic [lca_pkg::DEPTH_W-1:0] node_depth,
	input  logic [lca_pkg::NODE_W-1:0]  other_node,
	output logic                      done,
	output logic [lca_pkg::NODE_W-1:0]  ancestor,
	output logic                      found
);

	import lca_pkg::*;

	localparam logic [LVL_W-1:0]  LAST_LVL = LVL_W'(JUMP_LEVELS - 1);
	localparam logic [NODE_W-1:0] LAST_IDX = NODE_W'(MAX_NODES - 1);

	function automatic logic [JT_AW-1:0] jt_addr(input logic [LVL_W-1:0] l,
			input logic [NODE_W-1:0] n);
		return JT_AW'(l) * JT_AW'(MAX_NODES) + JT_AW'(n);
	endfunction

	state_t state_q, state_d;

	logic [NODE_W-1:0]  p_q, q_q, idx_q, clr_q;
	logic [DEPTH_W-1:0] dp_q, dq_q;
	logic [LVL_W-1:0]   lvl_q;
	logic               done_q, found_q;
	logic [NODE_W-1:0]  ancestor_q;

	logic               par_we, dep_we, jt_we;
	logic [NODE_W-1:0]  par_wa, par_ra_a, par_ra_b, dep_ra_a, dep_ra_b;
	logic [LINK_W-1:0]  par_wd, par_rd_a, par_rd_b;
	logic [DEPTH_W-1:0] dep_wd, dep_rd_a, dep_rd_b;
	logic [JT_AW-1:0]   jt_wa, jt_ra_a, jt_ra_b;
	logic [LINK_W-1:0]  jt_wd, jt_rd_a, jt_rd_b;

	logic               accept, lift_go, b_adv, b_last, c_fail;
	logic               fin, fin_found;
	logic [NODE_W-1:0]  fin_anc;
	logic [CMP_W-1:0]   need;
	logic [LVL_W-1:0]   lvl_m1;

	lca_ram #(.DEPTH(MAX_NODES), .WIDTH(LINK_W)) u_par (
		.clk     (clk),
		.we      (par_we),
		.waddr   (par_wa),
		.wdata   (par_wd),
		.raddr_a (par_ra_a),
		.raddr_b (par_ra_b),
		.rdata_a (par_rd_a),
		.rdata_b (par_rd_b)
	);

	lca_ram #(.DEPTH(MAX_NODES), .WIDTH(DEPTH_W)) u_dep (
		.clk     (clk),
		.we      (dep_we),
		.waddr   (par_wa),
		.wdata   (dep_wd),
		.raddr_a (dep_ra_a),
		.raddr_b (dep_ra_b),
		.rdata_a (dep_rd_a),
		.rdata_b (dep_rd_b)
	);

	lca_ram #(.DEPTH(JT_DEPTH), .WIDTH(LINK_W)) u_jt (
		.clk     (clk),
		.we      (jt_we),
		.waddr   (jt_wa),
		.wdata   (jt_wd),
		.raddr_a (jt_ra_a),
		.raddr_b (jt_ra_b),
		.rdata_a (jt_rd_a),
		.rdata_b (jt_rd_b)
	);

	// compare unit: lift when depth(p) - 2^lvl >= depth(q)
	assign need    = CMP_W'(dq_q) + (CMP_W'(1) << lvl_q);
	assign lift_go = CMP_W'(dp_q) >= need;
	assign lvl_m1  = lvl_q - LVL_W'(1);
	assign accept  = start && (state_q == S_IDLE);
	assign b_last  = (idx_q == LAST_IDX) && (lvl_q == LAST_LVL);
	assign c_fail  = (jt_rd_a == '0) != (jt_rd_b == '0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == LAST_IDX) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					case (cmd_t'(command))
						CMD_BUILD: state_d = S_B_RD;
						CMD_QUERY: state_d = S_Q_SWAP;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_B_RD:  state_d = S_B_MID;
			S_B_MID: begin
				if (b_adv) state_d = b_last ? S_IDLE : S_B_RD;
				else state_d = S_B_WR;
			end
			S_B_WR:   state_d = b_last ? S_IDLE : S_B_RD;
			S_Q_SWAP: state_d = S_L_CHK;
			S_L_CHK: begin
				if (lift_go) state_d = S_L_JMP;
				else if (lvl_q == '0) state_d = S_L_END;
			end
			S_L_JMP: state_d = (jt_rd_a == '0) ? S_IDLE : S_L_DEP;
			S_L_DEP: state_d = (lvl_q == '0) ? S_L_END : S_L_CHK;
			S_L_END: state_d = (p_q == q_q) ? S_IDLE : S_C_RD;
			S_C_RD:  state_d = S_C_CHK;
			S_C_CHK: begin
				if (c_fail) state_d = S_IDLE;
				else if (lvl_q == '0) state_d = S_P_RD;
				else state_d = S_C_RD;
			end
			S_P_RD:  state_d = S_P_CHK;
			S_P_CHK: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory controls and finish
	always_comb begin
		busy      = (state_q != S_IDLE);
		par_we    = 1'b0;
		dep_we    = 1'b0;
		par_wa    = node;
		par_wd    = has_parent ? (LINK_W'(parent_node) + LINK_W'(1)) : '0;
		dep_wd    = node_depth;
		par_ra_a  = p_q;
		par_ra_b  = q_q;
		dep_ra_a  = p_q;
		dep_ra_b  = q_q;
		jt_we     = 1'b0;
		jt_wa     = jt_addr(lvl_q, idx_q);
		jt_wd     = jt_rd_b;
		jt_ra_a   = jt_addr(lvl_q, p_q);
		jt_ra_b   = jt_addr(lvl_q, q_q);
		b_adv     = 1'b0;
		fin       = 1'b0;
		fin_found = 1'b0;
		fin_anc   = p_q;
		case (state_q)
			S_CLEAR: begin
				par_we = 1'b1;
				dep_we = 1'b1;
				par_wa = clr_q;
				par_wd = '0;
				dep_wd = '0;
			end
			S_IDLE: begin
				dep_ra_a = node;
				dep_ra_b = other_node;
				if (accept) begin
					case (cmd_t'(command))
						CMD_WRITE: begin
							par_we = 1'b1;
							dep_we = 1'b1;
							fin    = 1'b1;
						end
						CMD_BUILD, CMD_QUERY: fin = 1'b0;
						default: fin = 1'b1;
					endcase
				end
			end
			S_B_RD: begin
				par_ra_a = idx_q;
				jt_ra_a  = jt_addr(lvl_m1, idx_q);
			end
			S_B_MID: begin
				jt_ra_b = jt_addr(lvl_m1, NODE_W'(jt_rd_a - LINK_W'(1)));
				if (lvl_q == '0) begin
					b_adv = 1'b1;
					jt_wd = par_rd_a;
				end else if (jt_rd_a == '0) begin
					b_adv = 1'b1;
					jt_wd = '0;
				end
				jt_we = b_adv;
				fin   = b_adv && b_last;
			end
			S_B_WR: begin
				b_adv = 1'b1;
				jt_we = 1'b1;
				fin   = b_last;
			end
			S_L_JMP: begin
				dep_ra_a = NODE_W'(jt_rd_a - LINK_W'(1));
				fin      = (jt_rd_a == '0);
			end
			S_L_END: begin
				fin       = (p_q == q_q);
				fin_found = 1'b1;
			end
			S_C_CHK: fin = c_fail;
			S_P_CHK: begin
				fin       = 1'b1;
				fin_found = (par_rd_a != '0) && (par_rd_a == par_rd_b);
				fin_anc   = NODE_W'(par_rd_a - LINK_W'(1));
			end
			default: fin = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			done_q     <= 1'b0;
			found_q    <= 1'b0;
			ancestor_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == S_CLEAR) clr_q <= clr_q + NODE_W'(1);
			if (fin) begin
				found_q    <= fin_found;
				ancestor_q <= fin_found ? fin_anc : '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					p_q   <= node;
					q_q   <= other_node;
					lvl_q <= '0;
					idx_q <= '0;
				end
			end
			S_B_MID, S_B_WR: begin
				if (b_adv) begin
					if (idx_q == LAST_IDX) begin
						idx_q <= '0;
						lvl_q <= lvl_q + LVL_W'(1);
					end else begin
						idx_q <= idx_q + NODE_W'(1);
					end
				end
			end
			S_Q_SWAP: begin
				if (dep_rd_a < dep_rd_b) begin
					p_q  <= q_q;
					q_q  <= p_q;
					dp_q <= dep_rd_b;
					dq_q <= dep_rd_a;
				end else begin
					dp_q <= dep_rd_a;
					dq_q <= dep_rd_b;
				end
				lvl_q <= LAST_LVL;
			end
			S_L_CHK: begin
				if (!lift_go && lvl_q != '0) lvl_q <= lvl_m1;
			end
			S_L_JMP: p_q <= NODE_W'(jt_rd_a - LINK_W'(1));
			S_L_DEP: begin
				dp_q <= dep_rd_a;
				if (lvl_q != '0) lvl_q <= lvl_m1;
			end
			S_L_END: lvl_q <= LAST_LVL;
			S_C_CHK: begin
				if (jt_rd_a != '0 && jt_rd_a != jt_rd_b) begin
					p_q <= NODE_W'(jt_rd_a - LINK_W'(1));
					q_q <= NODE_W'(jt_rd_b - LINK_W'(1));
				end
				if (lvl_q != '0) lvl_q <= lvl_m1;
			end
			default: lvl_q <= lvl_q;
		endcase
	end

	assign done     = done_q;
	assign found    = found_q;
	assign ancestor = ancestor_q;

endmodule
